FILE: rtl/boek_pkg.sv
// Shared types, constants and helper functions of the bond-order energy kernel.
// Depends on nothing; boek_mul and the kernel unit import it.
package boek_pkg;

	localparam int FRACTION_BITS = 24;
	localparam int SCALE_FRAC    = 24;
	localparam int CFG_IDX_W     = 4;

	localparam logic [63:0]        LN2_Q30   = 64'd744261118;
	localparam logic signed [63:0] LOG2E_Q30 = 64'sd1549082005;
	localparam logic signed [63:0] SAT_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] SAT_MIN   = -SAT_MAX;
	localparam logic signed [64:0] SAT_MAX65 = 65'sh0_7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [64:0] SAT_MIN65 = -SAT_MAX65;
	localparam logic signed [63:0] ONE_Q     = 64'sd1 <<< FRACTION_BITS;

	localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = CFG_IDX_W'(1);

	typedef enum logic [4:0] {
		ST_IDLE, ST_SIGMA, ST_NORM, ST_SQR, ST_LOGP, ST_EXPK, ST_ETRM, ST_EDIV,
		ST_EFIN, ST_EX1, ST_EX2, ST_ESIG1, ST_ESIG2, ST_EPI, ST_EPP, ST_ACC,
		ST_R1, ST_R2, ST_D1, ST_D2, ST_DOUT, ST_LAST, ST_OUT
	} state_t;

	typedef struct packed {
		logic               start;
		logic signed [63:0] a;
		logic signed [63:0] b;
		logic [5:0]         s;
	} mul_req_t;

	typedef struct packed {
		logic               done;
		logic signed [63:0] res;
	} mul_rsp_t;

	function automatic logic signed [63:0] sext32(input logic [31:0] v);
		sext32 = {{32{v[31]}}, v};
	endfunction

	// Sum clamped symmetrically to the 64-bit saturation range.
	function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s > SAT_MAX65)
			sadd = SAT_MAX;
		else if (s < SAT_MIN65)
			sadd = SAT_MIN;
		else
			sadd = s[63:0];
	endfunction

	// Halving with truncation toward zero.
	function automatic logic signed [63:0] half(input logic signed [63:0] x);
		logic [63:0] mag;
		mag = x[63] ? 64'(-x) : 64'(x);
		mag = mag >> 1;
		half = x[63] ? -$signed(mag) : $signed(mag);
	endfunction

	function automatic logic signed [31:0] clamp32(input logic signed [63:0] x);
		if (x > 64'sd2147483647)
			clamp32 = 32'sh7FFF_FFFF;
		else if (x < -64'sd2147483648)
			clamp32 = 32'sh8000_0000;
		else
			clamp32 = x[31:0];
	endfunction

	function automatic logic signed [47:0] clamp48(input logic signed [63:0] x);
		if (x > 64'sd140737488355327)
			clamp48 = 48'sh7FFF_FFFF_FFFF;
		else if (x < -64'sd140737488355328)
			clamp48 = 48'sh8000_0000_0000;
		else
			clamp48 = x[47:0];
	endfunction

	// Rounded-up 2^34 / n; for dividends below 2^30 the product shifted by 34
	// gives the exact floor quotient.
	function automatic logic [63:0] recip(input logic [3:0] n);
		unique case (n)
			4'd1:    recip = 64'd17179869184;
			4'd2:    recip = 64'd8589934592;
			4'd3:    recip = 64'd5726623062;
			4'd4:    recip = 64'd4294967296;
			4'd5:    recip = 64'd3435973837;
			4'd6:    recip = 64'd2863311531;
			4'd7:    recip = 64'd2454267027;
			4'd8:    recip = 64'd2147483648;
			4'd9:    recip = 64'd1908874354;
			4'd10:   recip = 64'd1717986919;
			4'd11:   recip = 64'd1561806290;
			4'd12:   recip = 64'd1431655766;
			4'd13:   recip = 64'd1321528399;
			4'd14:   recip = 64'd1227133514;
			default: recip = 64'd0;
		endcase
	endfunction

endpackage

FILE: rtl/boek_if.sv
// Channel interfaces of the bond-order energy kernel: bond requests, results
// and configuration writes. No dependencies.
interface boek_bond_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] bo_total;
	logic signed [31:0] bo_pi;
	logic signed [31:0] bo_pipi;
	logic signed [31:0] diss_sigma;
	logic signed [31:0] de_pi;
	logic signed [31:0] de_pipi;
	logic signed [31:0] exp_factor;
	logic signed [31:0] power_exponent;
	logic               owner_local;
	logic               partner_local;
	logic               last_bond;
	modport source(output valid, bo_total, bo_pi, bo_pipi, diss_sigma, de_pi, de_pipi,
		exp_factor, power_exponent, owner_local, partner_local, last_bond, input ready);
	modport sink(input valid, bo_total, bo_pi, bo_pipi, diss_sigma, de_pi, de_pipi,
		exp_factor, power_exponent, owner_local, partner_local, last_bond, output ready);
endinterface

interface boek_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] deriv_total;
	logic signed [31:0] deriv_pi;
	logic signed [31:0] deriv_pipi;
	logic signed [47:0] atom_energy;
	logic               energy_valid;
	logic               end_of_atom;
	modport source(output valid, deriv_total, deriv_pi, deriv_pipi, atom_energy,
		energy_valid, end_of_atom, input ready);
	modport sink(input valid, deriv_total, deriv_pi, deriv_pipi, atom_energy,
		energy_valid, end_of_atom, output ready);
endinterface

interface boek_cfg_if;
	logic        valid;
	logic        ready;
	logic [3:0]  index;
	logic [31:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

FILE: rtl/boek_mul.sv
// Shared multiply unit: saturated (a*b) >> s with truncation toward zero.
// Depends on boek_pkg. Four 32x32 partial products, one per cycle.
module boek_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  boek_pkg::mul_req_t req,
	output boek_pkg::mul_rsp_t rsp
);
	import boek_pkg::*;

	logic [63:0]        ua_q, ub_q;
	logic               neg_q;
	logic [5:0]         s_q;
	logic [127:0]       acc_q;
	logic [2:0]         cnt_q;
	logic               busy_q, done_q;
	logic signed [63:0] res_q;

	logic [31:0]  a_half, b_half;
	logic [63:0]  prod;
	logic [127:0] pp, sh;
	logic [63:0]  mag;

	always_comb begin
		a_half = cnt_q[1] ? ua_q[63:32] : ua_q[31:0];
		b_half = cnt_q[0] ? ub_q[63:32] : ub_q[31:0];
		prod   = a_half * b_half;
		case (cnt_q[1:0])
			2'd0:    pp = {64'd0, prod};
			2'd3:    pp = {prod, 64'd0};
			default: pp = {32'd0, prod, 32'd0};
		endcase
		sh  = acc_q >> s_q;
		mag = (|sh[127:63]) ? 64'(SAT_MAX) : sh[63:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 3'd0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 3'd0;
			end else if (busy_q) begin
				if (cnt_q == 3'd4) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			ua_q  <= req.a[63] ? 64'(-req.a) : 64'(req.a);
			ub_q  <= req.b[63] ? 64'(-req.b) : 64'(req.b);
			neg_q <= req.a[63] ^ req.b[63];
			s_q   <= req.s;
			acc_q <= 128'd0;
		end else if (busy_q) begin
			if (cnt_q == 3'd4)
				res_q <= neg_q ? -$signed(mag) : $signed(mag);
			else
				acc_q <= acc_q + pp;
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = res_q;

endmodule

FILE: rtl/bond_order_energy_kernel_unit.sv
// Bond-order energy kernel: one bond request in, one result out.
// A bond with positive sigma needs 93 or 94 multiplies on the shared unit, a
// bond with non-positive sigma 39 or 40, and a bond between two ghosts none.
// One bond at a time. Asynchronous active-low reset clears the sequencer, the
// energy accumulator and the registers (scale 1.0, energies enabled).
module bond_order_energy_kernel_unit (
	input  logic       clk,
	input  logic       arst_n,
	boek_bond_if.sink  bond,
	boek_result_if.source result,
	boek_cfg_if.sink   cfg
);
	import boek_pkg::*;

	localparam logic signed [41:0] PW_SHIFT_OFF = 42'(FRACTION_BITS - 30);

	state_t state_q, state_d;
	logic   pend_q, pend_d;

	mul_req_t mreq;
	mul_rsp_t mrsp;
	logic     mul_op;
	state_t   mul_next;
	logic     fin;

	// Configuration registers.
	logic [31:0] scale_q;
	logic        enable_q;

	// Latched request.
	logic [31:0] bo_t_q, bo_p_q, bo_pp_q, de_s_q, de_p_q, de_pp_q, pbe1_q, pbe2_q;
	logic        own_q, par_q, last_q;

	// Working registers of the sequencer.
	logic signed [63:0] sigma_q, y_q, t_q, pw_q, ex_q, ebond_q, r_q, dsig_q;
	logic [63:0]        u_q, term_q, sum_q;
	logic [33:0]        m_q;
	logic signed [6:0]  p_q;
	logic [4:0]         i_q;
	logic [23:0]        frac_q;
	logic [3:0]         n_q;
	logic               exp_sel_q;
	logic signed [47:0] energy_sum_q;

	// Result register.
	logic signed [31:0] d0_q, d1_q, d2_q;
	logic signed [47:0] energy_q;
	logic               evalid_q;

	logic signed [33:0] sigma34;
	logic               sigma_pos;
	logic signed [6:0]  pm;
	logic signed [63:0] log_val;
	logic signed [41:0] shamt;
	logic signed [41:0] nshamt;
	logic signed [63:0] exp_res;
	logic signed [63:0] x1, x2;

	// The sigma order is total minus pi and double pi, exact in 34 bits.
	assign sigma34 = {{2{bo_t_q[31]}}, bo_t_q} - {{2{bo_p_q[31]}}, bo_p_q}
		- {{2{bo_pp_q[31]}}, bo_pp_q};
	assign sigma_pos = !sigma34[33] && (sigma34 != 34'sd0);

	// log2 result: integer part (p - fraction bits) above 24 fraction bits.
	assign pm      = p_q - 7'(FRACTION_BITS);
	assign log_val = {{33{pm[6]}}, pm, frac_q};

	// Exponent scaling of 2^y: floor integer part plus output fraction less 30.
	always_comb begin
		shamt  = {{2{y_q[63]}}, y_q[63:24]} + (exp_sel_q ? 42'sd0 : PW_SHIFT_OFF);
		nshamt = -shamt;
		if (shamt > 42'sd31)
			exp_res = SAT_MAX;
		else if (shamt >= 42'sd0)
			exp_res = $signed(sum_q << shamt[4:0]);
		else if (shamt <= -42'sd63)
			exp_res = 64'sd0;
		else
			exp_res = $signed(sum_q >> nshamt[5:0]);
	end

	assign x1 = sadd(-sext32(de_p_q), -dsig_q);
	assign x2 = sadd(-sext32(de_pp_q), -dsig_q);

	boek_mul u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (mreq),
		.rsp   (mrsp)
	);

	assign fin = pend_q && mrsp.done;

	// Sequencer: each arithmetic step names its multiply operands and the
	// step that follows once the shared unit returns.
	always_comb begin
		state_d  = state_q;
		pend_d   = pend_q;
		mul_op   = 1'b0;
		mul_next = state_q;
		mreq     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (bond.valid)
					state_d = ST_SIGMA;
			end
			ST_SIGMA: begin
				if (!(own_q || par_q))
					state_d = ST_LAST;
				else if (sigma_pos)
					state_d = ST_NORM;
				else
					state_d = ST_EX1;
			end
			ST_NORM: begin
				if (m_q[33:31] == 3'd0 && m_q[30])
					state_d = ST_SQR;
			end
			ST_SQR: begin
				mul_op   = 1'b1;
				mreq.a   = {30'd0, m_q};
				mreq.b   = {30'd0, m_q};
				mreq.s   = 6'd30;
				mul_next = (i_q == 5'd23) ? ST_LOGP : ST_SQR;
			end
			ST_LOGP: begin
				mul_op   = 1'b1;
				mreq.a   = sext32(pbe2_q);
				mreq.b   = log_val;
				mreq.s   = 6'(FRACTION_BITS);
				mul_next = ST_EXPK;
			end
			ST_EXPK: begin
				mul_op   = 1'b1;
				mreq.a   = {40'd0, y_q[23:0]};
				mreq.b   = LN2_Q30;
				mreq.s   = 6'd24;
				mul_next = ST_ETRM;
			end
			ST_ETRM: begin
				mul_op   = 1'b1;
				mreq.a   = term_q;
				mreq.b   = u_q;
				mreq.s   = 6'd30;
				mul_next = ST_EDIV;
			end
			ST_EDIV: begin
				mul_op   = 1'b1;
				mreq.a   = t_q;
				mreq.b   = recip(n_q);
				mreq.s   = 6'd34;
				mul_next = (n_q == 4'd14) ? ST_EFIN : ST_ETRM;
			end
			ST_EFIN: begin
				state_d = exp_sel_q ? ST_ESIG1 : ST_EX1;
			end
			ST_EX1: begin
				mul_op   = 1'b1;
				mreq.a   = sext32(pbe1_q);
				mreq.b   = ONE_Q - pw_q;
				mreq.s   = 6'(FRACTION_BITS);
				mul_next = ST_EX2;
			end
			ST_EX2: begin
				mul_op   = 1'b1;
				mreq.a   = t_q;
				mreq.b   = LOG2E_Q30;
				mreq.s   = 6'(FRACTION_BITS + 6);
				mul_next = ST_EXPK;
			end
			ST_ESIG1: begin
				mul_op   = 1'b1;
				mreq.a   = sext32(de_s_q);
				mreq.b   = sigma_q;
				mreq.s   = 6'(FRACTION_BITS);
				mul_next = ST_ESIG2;
			end
			ST_ESIG2: begin
				mul_op   = 1'b1;
				mreq.a   = t_q;
				mreq.b   = ex_q;
				mreq.s   = 6'd30;
				mul_next = ST_EPI;
			end
			ST_EPI: begin
				mul_op   = 1'b1;
				mreq.a   = sext32(de_p_q);
				mreq.b   = sext32(bo_p_q);
				mreq.s   = 6'(FRACTION_BITS);
				mul_next = ST_EPP;
			end
			ST_EPP: begin
				mul_op   = 1'b1;
				mreq.a   = sext32(de_pp_q);
				mreq.b   = sext32(bo_pp_q);
				mreq.s   = 6'(FRACTION_BITS);
				mul_next = ST_ACC;
			end
			ST_ACC: begin
				state_d = ST_R1;
			end
			ST_R1: begin
				mul_op   = 1'b1;
				mreq.a   = sext32(pbe1_q);
				mreq.b   = sext32(pbe2_q);
				mreq.s   = 6'(FRACTION_BITS);
				mul_next = ST_R2;
			end
			ST_R2: begin
				mul_op   = 1'b1;
				mreq.a   = t_q;
				mreq.b   = pw_q;
				mreq.s   = 6'(FRACTION_BITS);
				mul_next = ST_D1;
			end
			ST_D1: begin
				mul_op   = 1'b1;
				mreq.a   = sext32(de_s_q);
				mreq.b   = r_q;
				mreq.s   = 6'(FRACTION_BITS);
				mul_next = ST_D2;
			end
			ST_D2: begin
				mul_op   = 1'b1;
				mreq.a   = t_q;
				mreq.b   = ex_q;
				mreq.s   = 6'd30;
				mul_next = ST_DOUT;
			end
			ST_DOUT: begin
				state_d = ST_LAST;
			end
			ST_LAST: begin
				if (last_q && enable_q && own_q) begin
					mul_op   = 1'b1;
					mreq.a   = {{16{energy_sum_q[47]}}, energy_sum_q};
					mreq.b   = {32'd0, scale_q};
					mreq.s   = 6'(SCALE_FRAC);
					mul_next = ST_OUT;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (result.ready)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
		if (mul_op) begin
			if (!pend_q) begin
				mreq.start = 1'b1;
				pend_d     = 1'b1;
			end else if (mrsp.done) begin
				pend_d  = 1'b0;
				state_d = mul_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
		end
	end

	// Configuration writes; an index past the register list is dropped.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q  <= 32'd16777216;
			enable_q <= 1'b1;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_SCALE:  scale_q  <= cfg.data;
				CFG_ENABLE: enable_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// The accumulator gathers half bond energies of a local owner and is
	// cleared once the owner's last bond has been reported.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			energy_sum_q <= 48'sd0;
		end else if (state_q == ST_ACC && own_q) begin
			energy_sum_q <= clamp48(sadd({{16{energy_sum_q[47]}}, energy_sum_q},
				half(ebond_q)));
		end else if (state_q == ST_OUT && last_q) begin
			energy_sum_q <= 48'sd0;
		end
	end

	// Datapath registers, written by the step that owns them.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (bond.valid) begin
					bo_t_q  <= bond.bo_total;
					bo_p_q  <= bond.bo_pi;
					bo_pp_q <= bond.bo_pipi;
					de_s_q  <= bond.diss_sigma;
					de_p_q  <= bond.de_pi;
					de_pp_q <= bond.de_pipi;
					pbe1_q  <= bond.exp_factor;
					pbe2_q  <= bond.power_exponent;
					own_q   <= bond.owner_local;
					par_q   <= bond.partner_local;
					last_q  <= bond.last_bond;
				end
			end
			ST_SIGMA: begin
				sigma_q   <= {{30{sigma34[33]}}, sigma34};
				m_q       <= sigma34;
				p_q       <= 7'sd30;
				i_q       <= 5'd0;
				frac_q    <= 24'd0;
				pw_q      <= 64'sd0;
				exp_sel_q <= 1'b0;
				d0_q      <= 32'sd0;
				d1_q      <= 32'sd0;
				d2_q      <= 32'sd0;
				energy_q  <= 48'sd0;
				evalid_q  <= 1'b0;
			end
			ST_NORM: begin
				if (m_q[33:31] != 3'd0) begin
					m_q <= m_q >> 1;
					p_q <= p_q + 7'sd1;
				end else if (!m_q[30]) begin
					m_q <= m_q << 1;
					p_q <= p_q - 7'sd1;
				end
			end
			ST_SQR: begin
				if (fin) begin
					frac_q <= {frac_q[22:0], mrsp.res[31]};
					m_q    <= mrsp.res[31] ? {3'd0, mrsp.res[31:1]} : {2'd0, mrsp.res[31:0]};
					i_q    <= i_q + 5'd1;
				end
			end
			ST_LOGP: begin
				if (fin)
					y_q <= mrsp.res;
			end
			ST_EXPK: begin
				if (fin) begin
					u_q    <= mrsp.res;
					sum_q  <= 64'd1 << 30;
					term_q <= 64'd1 << 30;
					n_q    <= 4'd1;
				end
			end
			ST_ETRM: begin
				if (fin)
					t_q <= mrsp.res;
			end
			ST_EDIV: begin
				if (fin) begin
					term_q <= mrsp.res;
					sum_q  <= sum_q + 64'(mrsp.res);
					n_q    <= n_q + 4'd1;
				end
			end
			ST_EFIN: begin
				if (exp_sel_q)
					ex_q <= exp_res;
				else
					pw_q <= exp_res;
			end
			ST_EX1, ST_ESIG1, ST_R1, ST_D1: begin
				if (fin)
					t_q <= mrsp.res;
			end
			ST_EX2: begin
				if (fin) begin
					y_q       <= mrsp.res;
					exp_sel_q <= 1'b1;
				end
			end
			ST_ESIG2: begin
				if (fin)
					ebond_q <= -mrsp.res;
			end
			ST_EPI, ST_EPP: begin
				if (fin)
					ebond_q <= sadd(ebond_q, -mrsp.res);
			end
			ST_R2: begin
				if (fin)
					r_q <= sadd(mrsp.res, -ONE_Q);
			end
			ST_D2: begin
				if (fin)
					dsig_q <= mrsp.res;
			end
			ST_DOUT: begin
				// Ownership weight is 1 with both atoms local, else one half.
				d0_q <= clamp32((own_q && par_q) ? dsig_q : half(dsig_q));
				d1_q <= clamp32((own_q && par_q) ? x1 : half(x1));
				d2_q <= clamp32((own_q && par_q) ? x2 : half(x2));
			end
			ST_LAST: begin
				if (fin) begin
					energy_q <= clamp48(mrsp.res);
					evalid_q <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign bond.ready          = (state_q == ST_IDLE);
	assign result.valid        = (state_q == ST_OUT);
	assign result.deriv_total  = d0_q;
	assign result.deriv_pi     = d1_q;
	assign result.deriv_pipi   = d2_q;
	assign result.atom_energy  = energy_q;
	assign result.energy_valid = evalid_q;
	assign result.end_of_atom  = last_q;

	// A request is never taken while a result is still on offer.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		bond.ready |-> !result.valid)
		else $error("request accepted while a result is pending");

	// The multiply unit only answers a multiply that the sequencer issued.
	a_mul_done: assert property (@(posedge clk) disable iff (!arst_n)
		mrsp.done |-> pend_q)
		else $error("unexpected multiply completion");

	// An atom energy is only reported on the owner's last bond.
	a_energy_last: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.energy_valid |-> result.end_of_atom)
		else $error("atom energy without last bond");

	// Once a result is taken the block is ready for the next bond.
	a_back_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.ready |=> bond.ready)
		else $error("block did not return to idle");

endmodule
